>>> hdl/sol_pkg.sv
// Shared types and constants for the sorted list block.
package sol_pkg;

    localparam int CAPACITY = 128;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int STAT_W   = 2;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_FULL    = 2'd1,
        STATUS_MISSING = 2'd2
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    // Command broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } cell_ctl_t;

endpackage

>>> hdl/sol_req_if.sv
// Request channel carrying one list operation per beat.
interface sol_req_if import sol_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [DATA_W-1:0] key_value;

    modport source (output valid, output operation, output key_value, input ready);
    modport sink   (input valid, input operation, input key_value, output ready);
endinterface

>>> hdl/sol_rsp_if.sv
// Response channel carrying one result per beat.
interface sol_rsp_if import sol_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  entry_count;
    logic [DATA_W-1:0] smallest_value;

    modport source (output valid, output status, output position, output entry_count,
                    output smallest_value, input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    input smallest_value, output ready);
endinterface

>>> hdl/sorted_list_insert_delete.sv
// Sorted list top level: controller, row of cells, position encoder and result register.
// Each operation passes three steps in turn: accept (S_IDLE), compare (S_CMP), then shift and
// register (S_UPD), which waits while an unaccepted result is held; requests are taken only in S_IDLE.
// A new request is taken while an earlier result still waits in the output register.
// Reset empties the list at once (all cell valid bits and the count cleared); no clearing pass.
module sorted_list_insert_delete import sol_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    sol_req_if.sink   req,
    sol_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg;
    data_t  key_reg;
    cnt_t   count_reg, count_next;

    logic    out_valid_reg;
    status_t out_status_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [POS_W-1:0]  out_count_reg;
    data_t   out_small_reg;

    cell_ctl_t ctl;
    data_t     value_arr [CAPACITY];
    logic [CAPACITY-1:0] valid_vec, gt_vec, ge_vec, eq_vec;
    logic [CAPACITY-1:0] bnd_ins, bnd_del;
    idx_t    enc_ins, enc_del;
    logic    full, found, upd_fire, do_ins, do_del, req_fire;
    status_t res_status;
    cnt_t    res_pos;
    data_t   new_first;

    assign req_fire = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    assign full     = (count_reg == cnt_t'(CAPACITY));
    assign found    = |eq_vec;
    assign upd_fire = (state_reg == S_UPD) && (!out_valid_reg || rsp.ready);
    assign do_ins   = upd_fire && (op_reg == OP_INSERT) && !full;
    assign do_del   = upd_fire && (op_reg == OP_DELETE) && found;

    assign ctl.cmp = (state_reg == S_CMP);
    assign ctl.ins = do_ins;
    assign ctl.del = do_del;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            data_t l_value, r_value;
            logic  l_valid, l_gt, r_valid;
            if (i == 0)
            begin : g_first
                assign l_value = '0;
                assign l_valid = 1'b0;
                assign l_gt    = 1'b0;
            end
            else
            begin : g_mid
                assign l_value = value_arr[i-1];
                assign l_valid = valid_vec[i-1];
                assign l_gt    = gt_vec[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign r_value = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_inner
                assign r_value = value_arr[i+1];
                assign r_valid = valid_vec[i+1];
            end

            sol_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .key         (key_reg),
                .left_value  (l_value),
                .left_valid  (l_valid),
                .left_gt     (l_gt),
                .right_value (r_value),
                .right_valid (r_valid),
                .value       (value_arr[i]),
                .valid       (valid_vec[i]),
                .gt          (gt_vec[i]),
                .ge          (ge_vec[i]),
                .eq          (eq_vec[i])
            );
        end
    endgenerate

    // The flags are thermometer codes along the row; their rising edge marks the position.
    always_comb
    begin
        bnd_ins = '0;
        bnd_del = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i == 0)
            begin
                bnd_ins[i] = gt_vec[i];
                bnd_del[i] = ge_vec[i];
            end
            else
            begin
                bnd_ins[i] = gt_vec[i] && !gt_vec[i-1];
                bnd_del[i] = ge_vec[i] && !ge_vec[i-1];
            end
        end
    end

    always_comb
    begin
        enc_ins = '0;
        enc_del = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (bnd_ins[i])
            begin
                enc_ins = enc_ins | idx_t'(i);
            end
            if (bnd_del[i])
            begin
                enc_del = enc_del | idx_t'(i);
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        res_status = STATUS_DONE;
        res_pos    = count_reg;
        new_first  = value_arr[0];
        if (op_reg == OP_INSERT)
        begin
            if (full)
            begin
                res_status = STATUS_FULL;
            end
            else
            begin
                res_pos    = cnt_t'(enc_ins);
                count_next = count_reg + cnt_t'(1);
                if (gt_vec[0])
                begin
                    new_first = key_reg;
                end
            end
        end
        else
        begin
            if (!found)
            begin
                res_status = STATUS_MISSING;
            end
            else
            begin
                res_pos    = cnt_t'(enc_del);
                count_next = count_reg - cnt_t'(1);
                if (ge_vec[0])
                begin
                    new_first = value_arr[1];
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (upd_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (upd_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg  <= op_t'(req.operation);
            key_reg <= data_t'(req.key_value);
        end
        if (upd_fire)
        begin
            out_status_reg <= res_status;
            out_pos_reg    <= POS_W'(res_pos);
            out_count_reg  <= POS_W'(count_next);
            out_small_reg  <= (count_next != '0) ? new_first : '0;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.position       = out_pos_reg;
    assign rsp.entry_count    = out_count_reg;
    assign rsp.smallest_value = out_small_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(CAPACITY))
        else $error("entry count above capacity");

    a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("occupied cells disagree with entry count");

    a_one_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |-> $onehot0(bnd_ins) && $onehot0(bnd_del))
        else $error("more than one boundary in the cell row");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> count_reg == $past(count_reg) + cnt_t'(1))
        else $error("insert did not grow the list by one");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg == S_CMP)
        else $error("accepted request did not start a compare");
`endif

endmodule

>>> hdl/sol_cell.sv
// One storage cell of the sorted row: holds an entry, compares it and shifts.
module sol_cell import sol_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  data_t     key,
    input  data_t     left_value,
    input  logic      left_valid,
    input  logic      left_gt,
    input  data_t     right_value,
    input  logic      right_valid,
    output data_t     value,
    output logic      valid,
    output logic      gt,
    output logic      ge,
    output logic      eq
);

    data_t value_reg, value_next;
    logic  valid_reg, valid_next;
    logic  gt_reg, gt_next;
    logic  ge_reg, ge_next;
    logic  eq_reg, eq_next;

    // An empty cell counts as greater than any key, so the flags stay monotone.
    always_comb
    begin
        gt_next = gt_reg;
        ge_next = ge_reg;
        eq_next = eq_reg;
        if (ctl.cmp)
        begin
            gt_next = !valid_reg || (value_reg > key);
            ge_next = !valid_reg || (value_reg >= key);
            eq_next = valid_reg && (value_reg == key);
        end
    end

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.ins && gt_reg)
        begin
            if (left_gt)
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
            else
            begin
                value_next = key;
                valid_next = 1'b1;
            end
        end
        else if (ctl.del && ge_reg)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            gt_reg    <= 1'b0;
            ge_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            gt_reg    <= gt_next;
            ge_reg    <= ge_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign gt    = gt_reg;
    assign ge    = ge_reg;
    assign eq    = eq_reg;

endmodule
